[src/dtcc_pkg.sv]
// ----------------------------------------------------------------------------
// dtcc_pkg
// Shared types, constants and calendar tables for the date/time counter.
// ----------------------------------------------------------------------------
package dtcc_pkg;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_DATE = 2'd1,
        MODE_TIME = 2'd2,
        MODE_IDLE = 2'd3
    } dtcc_mode_t;

    localparam logic [15:0] YEAR_MIN   = 16'd2000;
    localparam logic [15:0] YEAR_MAX   = 16'd9999;
    localparam logic [15:0] MONTH_MAX  = 16'd12;
    localparam logic [7:0]  HOUR_MAX   = 8'd23;
    localparam logic [7:0]  MINSEC_MAX = 8'd59;
    localparam logic [12:0] RECIP_100  = 13'd5243;   // 2^19 / 100, rounded up
    localparam logic [14:0] RECIP_7    = 15'd18725;  // 2^17 / 7, rounded up

    // date loaded by a set-date beat, and the time loaded by a set-time beat
    typedef struct packed {
        dtcc_mode_t  mode;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [6:0]  year_mod100;
        logic [8:0]  year_mod400;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } dtcc_load_t;

    function automatic logic is_leap(input logic [1:0] low_bits,
                                     input logic [6:0] mod100,
                                     input logic [8:0] mod400);
        is_leap = ((low_bits == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        case (month)
            4'd2:    days_in = leap ? 5'd29 : 5'd28;
            4'd4:    days_in = 5'd30;
            4'd6:    days_in = 5'd30;
            4'd9:    days_in = 5'd30;
            4'd11:   days_in = 5'd30;
            default: days_in = 5'd31;
        endcase
    endfunction

    // (31 * shifted month) / 12, with March as the first month
    function automatic logic [4:0] month_term(input logic [3:0] month);
        case (month)
            4'd1:    month_term = 5'd28;
            4'd2:    month_term = 5'd31;
            4'd3:    month_term = 5'd2;
            4'd4:    month_term = 5'd5;
            4'd5:    month_term = 5'd7;
            4'd6:    month_term = 5'd10;
            4'd7:    month_term = 5'd12;
            4'd8:    month_term = 5'd15;
            4'd9:    month_term = 5'd18;
            4'd10:   month_term = 5'd20;
            4'd11:   month_term = 5'd23;
            4'd12:   month_term = 5'd25;
            default: month_term = 5'd0;
        endcase
    endfunction

endpackage

[src/dtcc_date_prep.sv]
// ----------------------------------------------------------------------------
// dtcc_date_prep
// Four-stage pipeline that clamps the loaded fields and computes the weekday.
// ----------------------------------------------------------------------------
module dtcc_date_prep
    import dtcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_beat,
    input  logic [1:0]  mode,
    input  logic [15:0] set_year,
    input  logic [15:0] set_month,
    input  logic [15:0] set_day,
    input  logic [7:0]  set_hour,
    input  logic [7:0]  set_minute,
    input  logic [7:0]  set_second,
    output logic        load_valid,
    output dtcc_load_t  load
);

    typedef struct packed {
        dtcc_mode_t  mode;
        logic [13:0] year;
        logic [13:0] yy;
        logic [3:0]  month;
        logic [15:0] day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } a_t;

    typedef struct packed {
        a_t          a;
        logic [6:0]  q_year;
        logic [6:0]  q_yy;
    } b_t;

    typedef struct packed {
        dtcc_mode_t  mode;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [6:0]  year_mod100;
        logic [8:0]  year_mod400;
        logic [14:0] sum;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } c_t;

    typedef struct packed {
        c_t          c;
        logic [10:0] q7;
    } d_t;

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    a_t   a_reg, a_next;
    b_t   b_reg, b_next;
    c_t   c_reg, c_next;
    d_t   d_reg, d_next;

    // stage a: clamp
    always_comb
    begin
        a_next.mode = dtcc_mode_t'(mode);
        if (set_year < YEAR_MIN)
            a_next.year = YEAR_MIN[13:0];
        else if (set_year > YEAR_MAX)
            a_next.year = YEAR_MAX[13:0];
        else
            a_next.year = set_year[13:0];
        if (set_month == 16'd0)
            a_next.month = 4'd1;
        else if (set_month > MONTH_MAX)
            a_next.month = MONTH_MAX[3:0];
        else
            a_next.month = set_month[3:0];
        a_next.yy     = a_next.year - ((a_next.month <= 4'd2) ? 14'd1 : 14'd0);
        a_next.day    = set_day;
        a_next.hour   = (set_hour > HOUR_MAX) ? HOUR_MAX[4:0] : set_hour[4:0];
        a_next.minute = (set_minute > MINSEC_MAX) ? MINSEC_MAX[5:0] : set_minute[5:0];
        a_next.second = (set_second > MINSEC_MAX) ? MINSEC_MAX[5:0] : set_second[5:0];
    end

    // stage b: quotients by 100
    logic [26:0] prod_year, prod_yy;

    always_comb
    begin
        prod_year     = {13'd0, a_reg.year} * {14'd0, RECIP_100};
        prod_yy       = {13'd0, a_reg.yy} * {14'd0, RECIP_100};
        b_next.a      = a_reg;
        b_next.q_year = prod_year[25:19];
        b_next.q_yy   = prod_yy[25:19];
    end

    // stage c: leap year, day clamp, weekday sum
    logic [13:0] hund, quad;
    logic [4:0]  q400;
    logic [4:0]  lim;
    logic        leap;

    always_comb
    begin
        q400 = b_reg.q_year[6:2];
        hund = {1'b0, b_reg.q_year, 6'd0} + {2'b0, b_reg.q_year, 5'd0}
             + {5'd0, b_reg.q_year, 2'd0};
        quad = {1'b0, q400, 8'd0} + {2'b0, q400, 7'd0} + {5'd0, q400, 4'd0};
        c_next.mode        = b_reg.a.mode;
        c_next.year        = b_reg.a.year;
        c_next.month       = b_reg.a.month;
        c_next.year_mod100 = 7'(b_reg.a.year - hund);
        c_next.year_mod400 = 9'(b_reg.a.year - quad);
        leap = is_leap(b_reg.a.year[1:0], c_next.year_mod100, c_next.year_mod400);
        lim  = days_in(b_reg.a.month, leap);
        if (b_reg.a.day == 16'd0)
            c_next.day = 5'd1;
        else if (b_reg.a.day > {11'd0, lim})
            c_next.day = lim;
        else
            c_next.day = b_reg.a.day[4:0];
        c_next.sum = {10'd0, c_next.day} + {1'b0, b_reg.a.yy}
                   + {3'd0, b_reg.a.yy[13:2]} - {8'd0, b_reg.q_yy}
                   + {10'd0, b_reg.q_yy[6:2]} + {10'd0, month_term(b_reg.a.month)};
        c_next.hour   = b_reg.a.hour;
        c_next.minute = b_reg.a.minute;
        c_next.second = b_reg.a.second;
    end

    // stage d: quotient by 7
    logic [29:0] prod_7;

    always_comb
    begin
        prod_7    = {15'd0, c_reg.sum} * {15'd0, RECIP_7};
        d_next.c  = c_reg;
        d_next.q7 = prod_7[27:17];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_beat;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

    logic [14:0] rem7;

    always_comb
    begin
        rem7 = d_reg.c.sum - ({1'b0, d_reg.q7, 3'd0} - {4'd0, d_reg.q7});
        load_valid       = d_valid_reg;
        load.mode        = d_reg.c.mode;
        load.year        = d_reg.c.year;
        load.month       = d_reg.c.month;
        load.day         = d_reg.c.day;
        load.year_mod100 = d_reg.c.year_mod100;
        load.year_mod400 = d_reg.c.year_mod400;
        load.wday        = rem7[2:0];
        load.hour        = d_reg.c.hour;
        load.minute      = d_reg.c.minute;
        load.second      = d_reg.c.second;
    end

endmodule

[src/date_time_calendar_counter.sv]
// ----------------------------------------------------------------------------
// date_time_calendar_counter
// Calendar clock with second tick, date load and time load.
// ----------------------------------------------------------------------------
// Each input beat (tick, set date, set time, or an unused mode that changes
// nothing) gives one result beat with the time after the update. A beat can
// be accepted every cycle while no result waits to be taken; each beat passes
// through the four-stage pipeline that clamps loaded fields and derives the
// weekday, whose last stage feeds the counter update and output register. The
// whole pipeline holds while a result waits to be taken.
module date_time_calendar_counter
    import dtcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] set_year,
    input  logic [15:0] set_month,
    input  logic [15:0] set_day,
    input  logic [7:0]  set_hour,
    input  logic [7:0]  set_minute,
    input  logic [7:0]  set_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] cur_year,
    output logic [3:0]  cur_month,
    output logic [4:0]  cur_day,
    output logic [4:0]  cur_hour,
    output logic [5:0]  cur_minute,
    output logic [5:0]  cur_second,
    output logic [2:0]  weekday,
    output logic        at_epoch
);

    logic       adv;
    logic       load_valid;
    dtcc_load_t load;

    logic [15:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [2:0]  wday_reg, wday_next;
    logic [6:0]  mod100_reg, mod100_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic        out_valid_reg;
    logic [15:0] oyear_reg;
    logic [3:0]  omonth_reg;
    logic [4:0]  oday_reg, ohour_reg;
    logic [5:0]  ominute_reg, osecond_reg;
    logic [2:0]  owday_reg;
    logic        oepoch_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    dtcc_date_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_beat    (in_valid),
        .mode       (mode),
        .set_year   (set_year),
        .set_month  (set_month),
        .set_day    (set_day),
        .set_hour   (set_hour),
        .set_minute (set_minute),
        .set_second (set_second),
        .load_valid (load_valid),
        .load       (load)
    );

    logic sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
    logic leap_now;

    always_comb
    begin
        leap_now   = is_leap(year_reg[1:0], mod100_reg, mod400_reg);
        sec_wrap   = (second_reg == MINSEC_MAX[5:0]);
        min_wrap   = sec_wrap && (minute_reg == MINSEC_MAX[5:0]);
        hour_wrap  = min_wrap && (hour_reg == HOUR_MAX[4:0]);
        day_wrap   = hour_wrap && (day_reg == days_in(month_reg, leap_now));
        month_wrap = day_wrap && (month_reg == MONTH_MAX[3:0]);

        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        wday_next   = wday_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;

        case (load.mode)
            MODE_TICK:
            begin
                second_next = sec_wrap ? 6'd0 : second_reg + 6'd1;
                if (sec_wrap)
                    minute_next = min_wrap ? 6'd0 : minute_reg + 6'd1;
                if (min_wrap)
                    hour_next = hour_wrap ? 5'd0 : hour_reg + 5'd1;
                if (hour_wrap)
                begin
                    wday_next = (wday_reg == 3'd6) ? 3'd0 : wday_reg + 3'd1;
                    day_next  = day_wrap ? 5'd1 : day_reg + 5'd1;
                end
                if (day_wrap)
                    month_next = month_wrap ? 4'd1 : month_reg + 4'd1;
                if (month_wrap)
                begin
                    year_next = year_reg + 16'd1;
                    if (year_reg == 16'hFFFF)
                    begin
                        mod100_next = 7'd0;
                        mod400_next = 9'd0;
                    end
                    else
                    begin
                        mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                        mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                    end
                end
            end
            MODE_DATE:
            begin
                year_next   = {2'd0, load.year};
                month_next  = load.month;
                day_next    = load.day;
                wday_next   = load.wday;
                mod100_next = load.year_mod100;
                mod400_next = load.year_mod400;
            end
            MODE_TIME:
            begin
                hour_next   = load.hour;
                minute_next = load.minute;
                second_next = load.second;
            end
            default:
            begin
                year_next = year_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= 16'd2000;
            month_reg     <= 4'd1;
            day_reg       <= 5'd1;
            hour_reg      <= 5'd0;
            minute_reg    <= 6'd0;
            second_reg    <= 6'd0;
            wday_reg      <= 3'd6;
            mod100_reg    <= 7'd0;
            mod400_reg    <= 9'd0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= load_valid;
            if (load_valid)
            begin
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                wday_reg   <= wday_next;
                mod100_reg <= mod100_next;
                mod400_reg <= mod400_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && load_valid)
        begin
            oyear_reg   <= year_next;
            omonth_reg  <= month_next;
            oday_reg    <= day_next;
            ohour_reg   <= hour_next;
            ominute_reg <= minute_next;
            osecond_reg <= second_next;
            owday_reg   <= wday_next;
            oepoch_reg  <= (year_next == 16'd2000) && (month_next == 4'd1)
                        && (day_next == 5'd1) && (hour_next == 5'd0)
                        && (minute_next == 6'd0) && (second_next == 6'd0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign cur_year   = oyear_reg;
    assign cur_month  = omonth_reg;
    assign cur_day    = oday_reg;
    assign cur_hour   = ohour_reg;
    assign cur_minute = ominute_reg;
    assign cur_second = osecond_reg;
    assign weekday    = owday_reg;
    assign at_epoch   = oepoch_reg;

endmodule

[src/dtcc_checker.sv]
// ----------------------------------------------------------------------------
// dtcc_checker
// Port-level checks for the date/time counter, bound to the top level.
// ----------------------------------------------------------------------------
module dtcc_checker
    import dtcc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] cur_year,
    input logic [3:0]  cur_month,
    input logic [4:0]  cur_day,
    input logic [4:0]  cur_hour,
    input logic [5:0]  cur_minute,
    input logic [5:0]  cur_second,
    input logic [2:0]  weekday,
    input logic        at_epoch
);

    // held result beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cur_year)
            && $stable(cur_second) && $stable(weekday))
        else $error("result beat changed while stalled");

    // time of day stays in range
    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cur_hour <= 5'd23 && cur_minute <= 6'd59 && cur_second <= 6'd59)
        else $error("time of day out of range");

    // date and weekday stay in range
    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cur_month >= 4'd1 && cur_month <= 4'd12 && cur_day >= 5'd1
            && weekday <= 3'd6)
        else $error("date or weekday out of range");

    // epoch flag agrees with the fields
    a_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> at_epoch == (cur_year == 16'd2000 && cur_month == 4'd1
            && cur_day == 5'd1 && cur_hour == 5'd0 && cur_minute == 6'd0
            && cur_second == 6'd0))
        else $error("epoch flag mismatch");

endmodule

bind date_time_calendar_counter dtcc_checker u_dtcc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cur_year   (cur_year),
    .cur_month  (cur_month),
    .cur_day    (cur_day),
    .cur_hour   (cur_hour),
    .cur_minute (cur_minute),
    .cur_second (cur_second),
    .weekday    (weekday),
    .at_epoch   (at_epoch)
);
